/* hdl/signed_torque_bridge_pwm_macros.svh */
// ---------------------------------------------------------------------------
// signed_torque_bridge_pwm_macros
// assertion macros used by the bridge pwm controller
// ---------------------------------------------------------------------------
`ifndef SIGNED_TORQUE_BRIDGE_PWM_MACROS_SVH
`define SIGNED_TORQUE_BRIDGE_PWM_MACROS_SVH

// same-cycle implication
`define STB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define STB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/stb_pkg.sv */
// ---------------------------------------------------------------------------
// stb_pkg
// types, codes and constants of the signed torque bridge pwm
// ---------------------------------------------------------------------------
`default_nettype none

package stb_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CMP_W       = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam int REG_W       = 16;
    localparam int TORQUE_W    = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int DIV_STEPS   = 32;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    localparam logic [REG_W-1:0] TOP_RESET = 16'd800;
    localparam logic [REG_W-1:0] MIN_RESET = 16'd100;
    localparam logic [REG_W-1:0] MAX_RESET = 16'd800;

    localparam logic [CFG_IDX_W-1:0] CFG_TOP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX = 2'd2;

    localparam logic OP_SET  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_FIN
    } state_t;

    typedef struct packed {
        logic tick;
        logic zero;
        logic capture;
        logic mul;
        logic div_step;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic is_zero;
    } dp_status_t;

endpackage

`default_nettype wire

/* hdl/stb_cmd_if.sv */
// ---------------------------------------------------------------------------
// stb_cmd_if
// input channel: opcode and signed torque word
// ---------------------------------------------------------------------------
`default_nettype none

interface stb_cmd_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic signed [16:0] torque;

    modport source (output valid, output opcode, output torque, input ready);
    modport sink   (input valid, input opcode, input torque, output ready);
endinterface

`default_nettype wire

/* hdl/stb_rsp_if.sv */
// ---------------------------------------------------------------------------
// stb_rsp_if
// output channel: pwm levels, enable and pending duties
// ---------------------------------------------------------------------------
`default_nettype none

interface stb_rsp_if;
    logic        valid;
    logic        ready;
    logic        out_a;
    logic        out_b;
    logic        bridge_enable;
    logic [15:0] duty_a;
    logic [15:0] duty_b;

    modport source (output valid, output out_a, output out_b, output bridge_enable,
                    output duty_a, output duty_b, input ready);
    modport sink   (input valid, input out_a, input out_b, input bridge_enable,
                    input duty_a, input duty_b, output ready);
endinterface

`default_nettype wire

/* hdl/stb_ctrl.sv */
// ---------------------------------------------------------------------------
// stb_ctrl
// sequencer for torque mapping and the output handshake
// ---------------------------------------------------------------------------
`default_nettype none

module stb_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output      logic               in_ready,
    output      logic               out_valid,
    input  wire logic               out_ready,
    input  wire stb_pkg::dp_status_t status,
    output      stb_pkg::ctrl_cmd_t  cmd
);
    import stb_pkg::*;

    `include "signed_torque_bridge_pwm_macros.svh"

    state_t             state_reg;
    state_t             state_next;
    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               accept;
    logic               last_step;
    logic               produce;

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign last_step = (step_reg == STEP_W'(DIV_STEPS - 1));
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && !status.is_tick && !status.is_zero)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (last_step)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.tick    = accept && status.is_tick;
                cmd.zero    = accept && !status.is_tick && status.is_zero;
                cmd.capture = accept && !status.is_tick && !status.is_zero;
            end
            S_MUL:
            begin
                cmd.mul = 1'b1;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        if (cmd.mul)
        begin
            step_next = '0;
        end
        else if (cmd.div_step)
        begin
            step_next = step_reg + STEP_W'(1);
        end
    end

    assign produce = cmd.tick || cmd.zero || cmd.finish;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (produce)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `STB_ASSERT_IMP(a_ready_only_idle, in_ready, state_reg == S_IDLE, "ready outside idle")
    `STB_ASSERT_IMP(a_fin_out_free, state_reg == S_FIN, !out_valid_reg, "output word overrun")
    `STB_ASSERT_NXT(a_set_starts_mul, cmd.capture, state_reg == S_MUL, "set word not started")
    `STB_ASSERT_NXT(a_mul_to_div, state_reg == S_MUL, state_reg == S_DIV && step_reg == '0,
        "divider not started")
    `STB_ASSERT_NXT(a_produce_valid, produce, out_valid_reg, "result word lost")

endmodule

`default_nettype wire

/* hdl/stb_dp.sv */
// ---------------------------------------------------------------------------
// stb_dp
// config, pwm counter, duty state and the mapping multiply and divide
// ---------------------------------------------------------------------------
`default_nettype none

module stb_dp
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [stb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [stb_pkg::REG_W-1:0]         cfg_data,
    input  wire logic                              opcode,
    input  wire logic signed [stb_pkg::TORQUE_W-1:0] torque,
    input  wire stb_pkg::ctrl_cmd_t                cmd,
    output      stb_pkg::dp_status_t               status,
    output      logic                              out_a,
    output      logic                              out_b,
    output      logic                              bridge_enable,
    output      logic [stb_pkg::REG_W-1:0]         duty_a,
    output      logic [stb_pkg::REG_W-1:0]         duty_b
);
    import stb_pkg::*;

    logic [REG_W-1:0]       top_reg;
    logic [REG_W-1:0]       min_reg;
    logic [REG_W-1:0]       max_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [REG_W-1:0]       act_a_reg;
    logic [REG_W-1:0]       act_a_next;
    logic [REG_W-1:0]       act_b_reg;
    logic [REG_W-1:0]       act_b_next;
    logic [REG_W-1:0]       pend_a_reg;
    logic [REG_W-1:0]       pend_a_next;
    logic [REG_W-1:0]       pend_b_reg;
    logic [REG_W-1:0]       pend_b_next;
    logic                   enable_reg;
    logic                   enable_next;

    logic [TORQUE_W-1:0]    raw;
    logic [TORQUE_W-1:0]    mag;
    logic [TORQUE_W-1:0]    mag_reg;
    logic                   side_reg;
    logic [TORQUE_W-1:0]    span;
    logic                   span_neg;
    logic [REG_W-1:0]       span_abs;
    logic                   span_neg_reg;
    logic [31:0]            product;
    logic [31:0]            dvd_reg;
    logic [31:0]            dvd_next;
    logic [REG_W-1:0]       rem_reg;
    logic [REG_W-1:0]       rem_next;
    logic [REG_W:0]         shifted;
    logic [REG_W:0]         diff;
    logic                   fits;

    logic [31:0]            quot;
    logic [32:0]            mapped;
    logic [REG_W-1:0]       duty;
    logic                   wrap;

    assign raw      = torque;
    assign mag      = raw[TORQUE_W-1] ? (~raw + TORQUE_W'(1)) : raw;
    assign status.is_tick = (opcode == OP_TICK);
    assign status.is_zero = (raw == '0);

    // span and its magnitude for the unsigned multiply
    assign span     = {1'b0, max_reg} - {1'b0, min_reg};
    assign span_neg = span[TORQUE_W-1];
    assign span_abs = span_neg ? REG_W'(~span + TORQUE_W'(1)) : span[REG_W-1:0];
    assign product  = 32'(mag_reg) * 32'(span_abs);

    // one restoring divide step
    assign shifted  = {rem_reg, dvd_reg[31]};
    assign fits     = shifted >= {1'b0, max_reg};
    assign diff     = shifted - {1'b0, max_reg};

    always_comb
    begin
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        if (cmd.mul)
        begin
            rem_next = '0;
            dvd_next = product;
        end
        else if (cmd.div_step)
        begin
            rem_next = fits ? diff[REG_W-1:0] : shifted[REG_W-1:0];
            dvd_next = {dvd_reg[30:0], fits};
        end
    end

    // offset, sign and clamp of the quotient
    assign quot = (max_reg == '0) ? '0 : dvd_reg;

    always_comb
    begin
        if (span_neg_reg)
        begin
            mapped = (quot >= {16'b0, min_reg}) ? '0 : {17'b0, min_reg - quot[REG_W-1:0]};
        end
        else
        begin
            mapped = {17'b0, min_reg} + {1'b0, quot};
        end
        duty = (mapped > {17'b0, top_reg}) ? top_reg : mapped[REG_W-1:0];
    end

    assign wrap = (CMP_W'(count_reg) >= CMP_W'(top_reg)) || (count_reg == '1);

    always_comb
    begin
        count_next  = count_reg;
        act_a_next  = act_a_reg;
        act_b_next  = act_b_reg;
        pend_a_next = pend_a_reg;
        pend_b_next = pend_b_reg;
        enable_next = enable_reg;
        if (cmd.tick)
        begin
            if (wrap)
            begin
                count_next = '0;
                act_a_next = pend_a_reg;
                act_b_next = pend_b_reg;
            end
            else
            begin
                count_next = count_reg + COUNT_WIDTH'(1);
            end
        end
        else if (cmd.zero)
        begin
            pend_a_next = '0;
            pend_b_next = '0;
            enable_next = 1'b0;
        end
        else if (cmd.finish)
        begin
            pend_a_next = side_reg ? duty : '0;
            pend_b_next = side_reg ? '0 : duty;
            enable_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg    <= TOP_RESET;
            min_reg    <= MIN_RESET;
            max_reg    <= MAX_RESET;
            count_reg  <= '0;
            act_a_reg  <= '0;
            act_b_reg  <= '0;
            pend_a_reg <= '0;
            pend_b_reg <= '0;
            enable_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_TOP: top_reg <= cfg_data;
                    CFG_MIN: min_reg <= cfg_data;
                    CFG_MAX: max_reg <= cfg_data;
                    default: ;
                endcase
            end
            count_reg  <= count_next;
            act_a_reg  <= act_a_next;
            act_b_reg  <= act_b_next;
            pend_a_reg <= pend_a_next;
            pend_b_reg <= pend_b_next;
            enable_reg <= enable_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mag_reg  <= mag;
            side_reg <= raw[TORQUE_W-1];
        end
        if (cmd.mul)
        begin
            span_neg_reg <= span_neg;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
    end

    assign out_a         = CMP_W'(count_reg) < CMP_W'(act_a_reg);
    assign out_b         = CMP_W'(count_reg) < CMP_W'(act_b_reg);
    assign bridge_enable = enable_reg;
    assign duty_a        = pend_a_reg;
    assign duty_b        = pend_b_reg;

endmodule

`default_nettype wire

/* hdl/signed_torque_bridge_pwm.sv */
// ---------------------------------------------------------------------------
// signed_torque_bridge_pwm
// sign-magnitude h-bridge pwm driven by a signed torque command
// ---------------------------------------------------------------------------
// channel  dir  word
// cmd      in   opcode, torque
// rsp      out  out_a, out_b, bridge_enable, duty_a, duty_b
// cfg      in   write only: top, min_torque, max_torque
//
// tick and zero-torque words: result valid the cycle after
// nonzero torque: captured, multiplied, then run through the 32-step serial divider
// cmd stalls during a torque mapping, and while a result waits and rsp is not ready
// async active-low reset loads register defaults, clears counter and duties
// ---------------------------------------------------------------------------
`default_nettype none

module signed_torque_bridge_pwm
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    stb_cmd_if.sink                            cmd,
    stb_rsp_if.source                          rsp,
    input  wire logic                          cfg_wr_en,
    input  wire logic [stb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [stb_pkg::REG_W-1:0]     cfg_data
);
    import stb_pkg::*;

    ctrl_cmd_t  ctrl;
    dp_status_t status;

    stb_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (ctrl)
    );

    stb_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .opcode        (cmd.opcode),
        .torque        (cmd.torque),
        .cmd           (ctrl),
        .status        (status),
        .out_a         (rsp.out_a),
        .out_b         (rsp.out_b),
        .bridge_enable (rsp.bridge_enable),
        .duty_a        (rsp.duty_a),
        .duty_b        (rsp.duty_b)
    );

endmodule

`default_nettype wire

/* tb/signed_torque_bridge_pwm_test.sv */
// ---------------------------------------------------------------------------
// signed_torque_bridge_pwm_test
// self-checking bench: a queue-fed driver sends torque set and tick words with
// random gaps, a monitor with random stalls compares every result word field
// by field against an in-bench model of the bridge, over a series of
// register settings that includes the extremes
// ---------------------------------------------------------------------------
module signed_torque_bridge_pwm_test;
    timeunit 1ns;
    timeprecision 1ps;

    import stb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic                opcode;
        logic [TORQUE_W-1:0] torque;
    } cmd_word_t;

    typedef struct packed {
        logic             out_a;
        logic             out_b;
        logic             bridge_enable;
        logic [REG_W-1:0] duty_a;
        logic [REG_W-1:0] duty_b;
    } rsp_word_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [REG_W-1:0]     cfg_data;

    stb_cmd_if cmd_ch ();
    stb_rsp_if rsp_ch ();

    signed_torque_bridge_pwm dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // bridge model state
    logic [REG_W-1:0]       top_reg;
    logic [REG_W-1:0]       min_reg;
    logic [REG_W-1:0]       max_reg;
    logic [COUNT_WIDTH-1:0] count_q;
    logic [REG_W-1:0]       active_a;
    logic [REG_W-1:0]       active_b;
    logic [REG_W-1:0]       pending_a;
    logic [REG_W-1:0]       pending_b;
    logic                   enable_q;

    cmd_word_t pending_words [$];
    rsp_word_t predicted_outputs [$];

    cmd_word_t sent_word;
    cmd_word_t next_word;
    rsp_word_t got_word;
    rsp_word_t want_word;

    int cmd_gap_left;
    int rsp_gap_left;
    int cmd_gap_max;
    int rsp_gap_max;
    int mismatches;
    int sets_sent;
    int ticks_sent;
    int results_seen;
    int settings_run;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [REG_W-1:0] scale_duty(input logic [TORQUE_W-1:0] mag);
        longint span;
        longint quot;
        longint duty;
        span = longint'(max_reg) - longint'(min_reg);
        quot = 0;
        if (max_reg != '0)
            quot = (longint'(mag) * span) / longint'(max_reg);
        duty = quot + longint'(min_reg);
        if (duty < 0)
            duty = 0;
        if (duty > longint'(top_reg))
            duty = longint'(top_reg);
        return duty[REG_W-1:0];
    endfunction

    function automatic rsp_word_t bridge_step(input cmd_word_t w);
        rsp_word_t         r;
        logic [TORQUE_W:0] neg_mag;
        if (w.opcode == OP_SET)
        begin
            if (w.torque == '0)
            begin
                pending_a = '0;
                pending_b = '0;
                enable_q  = 1'b0;
            end
            else if (!w.torque[TORQUE_W-1])
            begin
                pending_a = '0;
                pending_b = scale_duty(w.torque);
                enable_q  = 1'b1;
            end
            else
            begin
                neg_mag   = {1'b1, {TORQUE_W{1'b0}}} - {1'b0, w.torque};
                pending_a = scale_duty(neg_mag[TORQUE_W-1:0]);
                pending_b = '0;
                enable_q  = 1'b1;
            end
        end
        else
        begin
            if (count_q >= top_reg || count_q == '1)
            begin
                count_q  = '0;
                active_a = pending_a;
                active_b = pending_b;
            end
            else
                count_q = count_q + 1'b1;
        end
        r.out_a         = (count_q < active_a);
        r.out_b         = (count_q < active_b);
        r.bridge_enable = enable_q;
        r.duty_a        = pending_a;
        r.duty_b        = pending_b;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v)
        begin
            if (mismatches < 60)
                $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid  <= 1'b0;
            cmd_ch.opcode <= OP_TICK;
            cmd_ch.torque <= '0;
            cmd_gap_left = 0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                sent_word.opcode = cmd_ch.opcode;
                sent_word.torque = cmd_ch.torque;
                predicted_outputs.push_back(bridge_step(sent_word));
                if (sent_word.opcode == OP_SET)
                    sets_sent++;
                else
                    ticks_sent++;
                cmd_gap_left = $urandom_range(0, cmd_gap_max);
            end
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (cmd_gap_left > 0)
                begin
                    cmd_gap_left--;
                    cmd_ch.valid <= 1'b0;
                end
                else if (pending_words.size() != 0)
                begin
                    next_word = pending_words.pop_front();
                    cmd_ch.valid  <= 1'b1;
                    cmd_ch.opcode <= next_word.opcode;
                    cmd_ch.torque <= next_word.torque;
                end
                else
                    cmd_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            rsp_gap_left = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got_word.out_a         = rsp_ch.out_a;
                got_word.out_b         = rsp_ch.out_b;
                got_word.bridge_enable = rsp_ch.bridge_enable;
                got_word.duty_a        = rsp_ch.duty_a;
                got_word.duty_b        = rsp_ch.duty_b;
                if (predicted_outputs.size() == 0)
                begin
                    if (mismatches < 60)
                        $display("%0t: result word with nothing expected, got %h",
                                 $time, got_word);
                    mismatches++;
                end
                else
                begin
                    want_word = predicted_outputs.pop_front();
                    check_field("out_a", want_word.out_a, got_word.out_a);
                    check_field("out_b", want_word.out_b, got_word.out_b);
                    check_field("bridge_enable", want_word.bridge_enable,
                                got_word.bridge_enable);
                    check_field("duty_a", want_word.duty_a, got_word.duty_a);
                    check_field("duty_b", want_word.duty_b, got_word.duty_b);
                end
                results_seen++;
                rsp_gap_left = $urandom_range(0, rsp_gap_max);
            end
            if (rsp_gap_left > 0)
            begin
                rsp_gap_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    task automatic drain_all();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || cmd_ch.valid || predicted_outputs.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == CFG_TOP)
            top_reg = val;
        else if (idx == CFG_MIN)
            min_reg = val;
        else if (idx == CFG_MAX)
            max_reg = val;
    endtask

    task automatic apply_setting(input int unsigned t, input int unsigned mn,
                                 input int unsigned mx, input bit spare);
        drain_all();
        repeat (40) @(posedge clk);
        write_reg(CFG_TOP, t[REG_W-1:0]);
        write_reg(CFG_MIN, mn[REG_W-1:0]);
        write_reg(CFG_MAX, mx[REG_W-1:0]);
        if (spare)
            write_reg(CFG_SPARE, 16'h0001);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic push_word(input logic op, input logic [TORQUE_W-1:0] t);
        cmd_word_t w;
        w.opcode = op;
        w.torque = t;
        pending_words.push_back(w);
    endtask

    function automatic logic [TORQUE_W-1:0] pick_torque();
        int lim;
        int mag;
        bit neg;
        logic [TORQUE_W-1:0] t;
        lim = (max_reg == '0) ? 300 : int'(max_reg) + int'(max_reg) / 4 + 1;
        if (lim > 65536)
            lim = 65536;
        neg = $urandom_range(0, 1);
        mag = $urandom_range(1, lim);
        if (!neg && mag > 65535)
            mag = 65535;
        case ($urandom_range(0, 11))
            0:       t = '0;
            1:       t = 17'h10000;
            2:       t = 17'h0FFFF;
            3:       t = 17'h10001;
            4, 5:    t = $urandom_range(0, 17'h1FFFF);
            default: t = neg ? 17'(-mag) : 17'(mag);
        endcase
        return t;
    endfunction

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            // hold off the sender once per setting until all results are back
            if (i == n / 2)
                drain_all();
            if ($urandom_range(0, 9) < 7)
                push_word(OP_TICK, $urandom_range(0, 17'h1FFFF));
            else
                push_word(OP_SET, pick_torque());
        end
    endtask

    task automatic set_gaps(input int ph);
        drain_all();
        case (ph % 4)
            0:       begin cmd_gap_max = 11; rsp_gap_max = 11; end
            1:       begin cmd_gap_max = 0;  rsp_gap_max = 0;  end
            2:       begin cmd_gap_max = 11; rsp_gap_max = 0;  end
            default: begin cmd_gap_max = 0;  rsp_gap_max = 11; end
        endcase
    endtask

    initial
    begin
        int unsigned tops [11];
        int unsigned mins [11];
        int unsigned maxs [11];
        tops = '{4, 40, 3, 50, 20, 0, 1, 65535, 65535, 25, 0};
        mins = '{2, 0, 1, 40, 15, 5, 65535, 0, 65535, 60000, 0};
        maxs = '{10, 65535, 5, 10, 0, 5, 1, 65535, 65535, 30000, 0};

        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = CFG_TOP;
        cfg_data      = '0;
        cmd_ch.valid  = 1'b0;
        cmd_ch.opcode = OP_TICK;
        cmd_ch.torque = '0;
        rsp_ch.ready  = 1'b0;
        top_reg       = TOP_RESET;
        min_reg       = MIN_RESET;
        max_reg       = MAX_RESET;
        count_q       = '0;
        active_a      = '0;
        active_b      = '0;
        pending_a     = '0;
        pending_b     = '0;
        enable_q      = 1'b0;
        cmd_gap_max   = 11;
        rsp_gap_max   = 11;
        mismatches    = 0;
        sets_sent     = 0;
        ticks_sent    = 0;
        results_seen  = 0;
        settings_run  = 1;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset register values: zero, unit, extremes and clamp to top
        push_word(OP_SET, 17'h00000);
        push_word(OP_SET, 17'h00001);
        push_word(OP_SET, 17'h1FFFF);
        push_word(OP_SET, 17'h0FFFF);
        push_word(OP_SET, 17'h10000);
        push_word(OP_SET, 17'h10001);
        push_word(OP_SET, 17'd800);
        push_word(OP_SET, 17'(-400));
        push_word(OP_TICK, 17'h1FFFF);
        push_word(OP_TICK, 17'h00000);
        push_word(OP_SET, 17'h00000);
        push_word(OP_TICK, 17'h10000);
        queue_random(85);

        // short period: duties load at wrap
        apply_setting(tops[0], mins[0], maxs[0], 1'b0);
        settings_run++;
        push_word(OP_SET, 17'd10);
        repeat (6) push_word(OP_TICK, 17'h0);
        push_word(OP_SET, 17'(-3));
        repeat (6) push_word(OP_TICK, 17'h0);
        queue_random(85);

        for (int ph = 1; ph < 13; ph++)
        begin
            set_gaps(ph);
            if (ph < 10)
                apply_setting(tops[ph], mins[ph], maxs[ph], ph == 5);
            else if (ph == 10)
                apply_setting($urandom_range(1, 60), $urandom_range(0, 100),
                              $urandom_range(1, 200), 1'b0);
            else
                apply_setting($urandom_range(1, 100), $urandom_range(0, 65535),
                              $urandom_range(0, 65535), 1'b0);
            settings_run++;
            queue_random(85);
        end

        drain_all();
        repeat (40) @(posedge clk);
        $display("sent %0d words (%0d torque sets, %0d ticks) over %0d register settings",
                 sets_sent + ticks_sent, sets_sent, ticks_sent, settings_run);
        $display("checked %0d result words, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0 && predicted_outputs.size() == 0)
            $display("signed_torque_bridge_pwm_test: clean");
        else
            $display("signed_torque_bridge_pwm_test: errors");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("signed_torque_bridge_pwm_test: errors");
        $finish;
    end

endmodule
